/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sector cache checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SCL_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sector cache assertion failed");

// next-cycle implication
`define SCL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sector cache assertion failed");

`endif

/* hw/rtl/scl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_pkg
// Types, sizes and helpers of the sector cache tag and replacement engine.
// ----------------------------------------------------------------------------
package scl_pkg;

   localparam int SLOTS        = 1024;
   localparam int PREFETCH_RUN = 16;

   localparam int IDX_W    = $clog2(SLOTS);
   localparam int RUN_W    = $clog2(PREFETCH_RUN + 1);
   localparam int SUM_W    = IDX_W + RUN_W;
   localparam int WORD_W   = 32;
   localparam int SLOT_FW  = 10;
   localparam int COUNT_FW = 5;

   typedef logic [IDX_W-1:0]    idx_type;
   typedef logic [IDX_W:0]      cnt_type;
   typedef logic [RUN_W-1:0]    run_type;
   typedef logic [SUM_W-1:0]    sum_type;
   typedef logic [WORD_W-1:0]   word_type;
   typedef logic [SLOT_FW-1:0]  slot_field_type;
   typedef logic [COUNT_FW-1:0] count_field_type;

   typedef enum logic [1:0] {
      OP_LOOKUP    = 2'd0,
      OP_FILL_DONE = 2'd1,
      OP_INVAL     = 2'd2,
      OP_FLUSH     = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      RS_HIT    = 3'd0,
      RS_REQ    = 3'd1,
      RS_FILLED = 3'd2,
      RS_ERR    = 3'd3,
      RS_DONE   = 3'd4,
      RS_BUSY   = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      RES_NONE,
      RES_BUSY,
      RES_NOPEND,
      RES_FILL_ERR,
      RES_FILLED,
      RES_HIT,
      RES_MISS,
      RES_INVAL_HIT,
      RES_INVAL_MISS,
      RES_FLUSH
   } res_type;

   typedef enum logic [2:0] {
      FSM_INIT,
      FSM_IDLE,
      FSM_DECODE,
      FSM_SCAN,
      FSM_FILL,
      FSM_FLUSH,
      FSM_RESP
   } fsm_type;

   typedef struct packed {
      logic    load;
      logic    cnt_clr;
      logic    scan_step;
      logic    clear_step;
      logic    fill_clr;
      logic    fill_step;
      res_type res_sel;
      logic    emit;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   pending;
      logic   fill_ok;
      logic   hit;
      logic   scan_last;
      logic   clear_last;
      logic   fill_last;
      logic   out_free;
   } sts_type;

   function automatic slot_field_type fmt_slot(input idx_type i);
      logic [IDX_W+SLOT_FW-1:0] w;
      w = {{SLOT_FW{1'b0}}, i};
      return w[SLOT_FW-1:0];
   endfunction

   function automatic count_field_type fmt_count(input run_type c);
      logic [RUN_W+COUNT_FW-1:0] w;
      w = {{COUNT_FW{1'b0}}, c};
      return w[COUNT_FW-1:0];
   endfunction

endpackage

/* hw/rtl/scl_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_req_if
// Request channel: operation, sector, time tick and fill result.
// ----------------------------------------------------------------------------
interface scl_req_if;
   logic              valid;
   logic              ready;
   scl_pkg::op_type   op;
   scl_pkg::word_type sector;
   scl_pkg::word_type now_tick;
   logic              fill_ok;

   modport source(output valid, op, sector, now_tick, fill_ok, input ready);
   modport sink(input valid, op, sector, now_tick, fill_ok, output ready);
endinterface

/* hw/rtl/scl_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_rsp_if
// Response channel: status, slot and fill request fields.
// ----------------------------------------------------------------------------
interface scl_rsp_if;
   logic                     valid;
   logic                     ready;
   scl_pkg::status_type      status;
   scl_pkg::slot_field_type  slot;
   scl_pkg::word_type        fill_sector;
   scl_pkg::count_field_type fill_count;

   modport source(output valid, status, slot, fill_sector, fill_count, input ready);
   modport sink(input valid, status, slot, fill_sector, fill_count, output ready);
endinterface

/* hw/rtl/scl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/scl_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_datapath
// Tag and stamp memories, slot scan, LRU victim tracking, pending fill and
// response registers.
// ----------------------------------------------------------------------------
module scl_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  scl_pkg::cmd_type         cmd,
   output scl_pkg::sts_type         sts,
   input  scl_pkg::op_type          in_op,
   input  scl_pkg::word_type        in_sector,
   input  scl_pkg::word_type        in_tick,
   input  logic                     in_ok,
   output logic                     out_valid,
   input  logic                     out_ready,
   output scl_pkg::status_type      out_status,
   output scl_pkg::slot_field_type  out_slot,
   output scl_pkg::word_type        out_sector,
   output scl_pkg::count_field_type out_count
);

   // captured request
   scl_pkg::op_type   op_ff;
   scl_pkg::word_type sector_ff, tick_ff;
   logic              ok_ff;

   // scan
   scl_pkg::cnt_type  cnt_ff, cnt_in;
   logic              rd_vld_ff, rd_vld_in;
   scl_pkg::idx_type  rd_idx_ff;
   scl_pkg::word_type oldest_ff, oldest_in;
   scl_pkg::idx_type  victim_ff, victim_in;
   scl_pkg::word_type rd_tag, rd_stamp;
   logic              rd_en;
   logic              older;

   // pending fill
   logic              pending_ff, pending_in;
   scl_pkg::idx_type  pend_slot_ff, pend_slot_in;
   scl_pkg::word_type pend_sector_ff, pend_sector_in;
   scl_pkg::run_type  pend_count_ff, pend_count_in;
   scl_pkg::word_type pend_tick_ff, pend_tick_in;
   scl_pkg::run_type  fill_idx_ff, fill_idx_in;
   scl_pkg::sum_type  fill_sum, miss_sum;
   scl_pkg::run_type  miss_count;

   // staged and output results
   scl_pkg::status_type res_status_ff, res_status_in;
   scl_pkg::idx_type    res_slot_ff, res_slot_in;
   scl_pkg::word_type   res_sector_ff, res_sector_in;
   scl_pkg::run_type    res_count_ff, res_count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   scl_pkg::status_type rsp_status_ff;
   scl_pkg::idx_type    rsp_slot_ff;
   scl_pkg::word_type   rsp_sector_ff;
   scl_pkg::run_type    rsp_count_ff;

   // memory write ports
   logic              tag_we, stamp_we;
   scl_pkg::idx_type  tag_wa, stamp_wa;
   scl_pkg::word_type tag_wd, stamp_wd;

   scl_ram #(.WIDTH(scl_pkg::WORD_W), .DEPTH(scl_pkg::SLOTS)) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (tag_wa),
      .wr_data (tag_wd),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[scl_pkg::IDX_W-1:0]),
      .rd_data (rd_tag)
   );

   scl_ram #(.WIDTH(scl_pkg::WORD_W), .DEPTH(scl_pkg::SLOTS)) u_stamp_ram (
      .clock   (clock),
      .wr_en   (stamp_we),
      .wr_addr (stamp_wa),
      .wr_data (stamp_wd),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[scl_pkg::IDX_W-1:0]),
      .rd_data (rd_stamp)
   );

   assign rd_en     = cmd.scan_step && (cnt_ff < scl_pkg::cnt_type'(scl_pkg::SLOTS));
   assign rd_vld_in = rd_en;
   assign older     = rd_stamp < oldest_ff;
   assign oldest_in = older ? rd_stamp : oldest_ff;
   assign victim_in = older ? rd_idx_ff : victim_ff;

   assign fill_sum   = scl_pkg::sum_type'(pend_slot_ff) + scl_pkg::sum_type'(fill_idx_ff);
   assign miss_sum   = scl_pkg::sum_type'(victim_in)
                     + scl_pkg::sum_type'(scl_pkg::PREFETCH_RUN);
   assign miss_count = (miss_sum < scl_pkg::sum_type'(scl_pkg::SLOTS))
                     ? scl_pkg::run_type'(scl_pkg::PREFETCH_RUN) : scl_pkg::run_type'(1);

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.scan_step || cmd.clear_step) begin
         cnt_in = cnt_ff + 1'b1;
      end
      fill_idx_in = fill_idx_ff;
      if (cmd.fill_clr) begin
         fill_idx_in = '0;
      end else if (cmd.fill_step) begin
         fill_idx_in = fill_idx_ff + 1'b1;
      end
   end

   // memory write arbitration
   always_comb begin
      tag_we   = 1'b0;
      tag_wa   = fill_sum[scl_pkg::IDX_W-1:0];
      tag_wd   = pend_sector_ff + scl_pkg::word_type'(fill_idx_ff);
      stamp_we = 1'b0;
      stamp_wa = rd_idx_ff;
      stamp_wd = '0;
      if (cmd.clear_step) begin
         stamp_we = 1'b1;
         stamp_wa = cnt_ff[scl_pkg::IDX_W-1:0];
      end else if (cmd.fill_step) begin
         tag_we   = fill_sum < scl_pkg::sum_type'(scl_pkg::SLOTS);
         stamp_we = tag_we;
         stamp_wa = fill_sum[scl_pkg::IDX_W-1:0];
         stamp_wd = pend_tick_ff;
      end else if (cmd.res_sel == scl_pkg::RES_HIT) begin
         stamp_we = 1'b1;
         stamp_wd = tick_ff;
      end else if (cmd.res_sel == scl_pkg::RES_INVAL_HIT) begin
         stamp_we = 1'b1;
      end
   end

   // result staging and pending fill
   always_comb begin
      res_status_in  = res_status_ff;
      res_slot_in    = res_slot_ff;
      res_sector_in  = res_sector_ff;
      res_count_in   = res_count_ff;
      pending_in     = pending_ff;
      pend_slot_in   = pend_slot_ff;
      pend_sector_in = pend_sector_ff;
      pend_count_in  = pend_count_ff;
      pend_tick_in   = pend_tick_ff;
      case (cmd.res_sel) inside
         scl_pkg::RES_BUSY: begin
            res_status_in = scl_pkg::RS_BUSY;
            res_slot_in   = '0;
            res_sector_in = '0;
            res_count_in  = '0;
         end
         scl_pkg::RES_NOPEND: begin
            res_status_in = scl_pkg::RS_ERR;
            res_slot_in   = '0;
            res_sector_in = '0;
            res_count_in  = '0;
         end
         scl_pkg::RES_FILL_ERR, scl_pkg::RES_FILLED: begin
            res_status_in = (cmd.res_sel == scl_pkg::RES_FILLED)
                          ? scl_pkg::RS_FILLED : scl_pkg::RS_ERR;
            res_slot_in   = pend_slot_ff;
            res_sector_in = pend_sector_ff;
            res_count_in  = pend_count_ff;
            pending_in    = 1'b0;
         end
         scl_pkg::RES_HIT: begin
            res_status_in = scl_pkg::RS_HIT;
            res_slot_in   = rd_idx_ff;
            res_sector_in = '0;
            res_count_in  = '0;
         end
         scl_pkg::RES_MISS: begin
            res_status_in  = scl_pkg::RS_REQ;
            res_slot_in    = victim_in;
            res_sector_in  = sector_ff;
            res_count_in   = miss_count;
            pending_in     = 1'b1;
            pend_slot_in   = victim_in;
            pend_sector_in = sector_ff;
            pend_count_in  = miss_count;
            pend_tick_in   = tick_ff;
         end
         scl_pkg::RES_INVAL_HIT: begin
            res_status_in = scl_pkg::RS_DONE;
            res_slot_in   = rd_idx_ff;
            res_sector_in = '0;
            res_count_in  = '0;
         end
         scl_pkg::RES_INVAL_MISS, scl_pkg::RES_FLUSH: begin
            res_status_in = scl_pkg::RS_DONE;
            res_slot_in   = '0;
            res_sector_in = '0;
            res_count_in  = '0;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff         <= '0;
         rd_vld_ff      <= 1'b0;
         fill_idx_ff    <= '0;
         pending_ff     <= 1'b0;
         pend_slot_ff   <= '0;
         pend_sector_ff <= '0;
         pend_count_ff  <= '0;
         pend_tick_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         cnt_ff         <= cnt_in;
         rd_vld_ff      <= rd_vld_in;
         fill_idx_ff    <= fill_idx_in;
         pending_ff     <= pending_in;
         pend_slot_ff   <= pend_slot_in;
         pend_sector_ff <= pend_sector_in;
         pend_count_ff  <= pend_count_in;
         pend_tick_ff   <= pend_tick_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= in_op;
         sector_ff <= in_sector;
         tick_ff   <= in_tick;
         ok_ff     <= in_ok;
      end
      rd_idx_ff <= cnt_ff[scl_pkg::IDX_W-1:0];
      if (cmd.cnt_clr) begin
         oldest_ff <= '1;
         victim_ff <= '0;
      end else if (rd_vld_ff) begin
         oldest_ff <= oldest_in;
         victim_ff <= victim_in;
      end
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_sector_ff <= res_sector_in;
      res_count_ff  <= res_count_in;
      if (cmd.emit) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= res_slot_ff;
         rsp_sector_ff <= res_sector_ff;
         rsp_count_ff  <= res_count_ff;
      end
   end

   assign sts.op         = op_ff;
   assign sts.pending    = pending_ff;
   assign sts.fill_ok    = ok_ff;
   assign sts.hit        = rd_vld_ff && (rd_stamp != '0) && (rd_tag == sector_ff);
   assign sts.scan_last  = rd_vld_ff && (rd_idx_ff == scl_pkg::idx_type'(scl_pkg::SLOTS - 1));
   assign sts.clear_last = cnt_ff == scl_pkg::cnt_type'(scl_pkg::SLOTS - 1);
   assign sts.fill_last  = fill_idx_ff == scl_pkg::run_type'(pend_count_ff - 1'b1);
   assign sts.out_free   = !rsp_valid_ff || out_ready;

   assign out_valid  = rsp_valid_ff;
   assign out_status = rsp_status_ff;
   assign out_slot   = scl_pkg::fmt_slot(rsp_slot_ff);
   assign out_sector = rsp_sector_ff;
   assign out_count  = scl_pkg::fmt_count(rsp_count_ff);

endmodule

/* hw/rtl/scl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_ctrl
// Sequencer: clearing pass, request decode, slot scan, fill commit, flush
// and response hand-off.
// ----------------------------------------------------------------------------
module scl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  scl_pkg::sts_type sts,
   output scl_pkg::cmd_type cmd
);

   scl_pkg::fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scl_pkg::FSM_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.res_sel = scl_pkg::RES_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         scl_pkg::FSM_INIT: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               state_in = scl_pkg::FSM_IDLE;
            end
         end
         scl_pkg::FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = scl_pkg::FSM_DECODE;
            end
         end
         scl_pkg::FSM_DECODE: begin
            unique case (sts.op)
               scl_pkg::OP_LOOKUP: begin
                  if (sts.pending) begin
                     cmd.res_sel = scl_pkg::RES_BUSY;
                     state_in    = scl_pkg::FSM_RESP;
                  end else begin
                     cmd.cnt_clr = 1'b1;
                     state_in    = scl_pkg::FSM_SCAN;
                  end
               end
               scl_pkg::OP_FILL_DONE: begin
                  if (!sts.pending) begin
                     cmd.res_sel = scl_pkg::RES_NOPEND;
                     state_in    = scl_pkg::FSM_RESP;
                  end else if (!sts.fill_ok) begin
                     cmd.res_sel = scl_pkg::RES_FILL_ERR;
                     state_in    = scl_pkg::FSM_RESP;
                  end else begin
                     cmd.fill_clr = 1'b1;
                     state_in     = scl_pkg::FSM_FILL;
                  end
               end
               scl_pkg::OP_INVAL: begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = scl_pkg::FSM_SCAN;
               end
               scl_pkg::OP_FLUSH: begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = scl_pkg::FSM_FLUSH;
               end
               default: begin
                  state_in = scl_pkg::FSM_IDLE;
               end
            endcase
         end
         scl_pkg::FSM_SCAN: begin
            if (sts.hit) begin
               cmd.res_sel = (sts.op == scl_pkg::OP_LOOKUP)
                           ? scl_pkg::RES_HIT : scl_pkg::RES_INVAL_HIT;
               state_in    = scl_pkg::FSM_RESP;
            end else if (sts.scan_last) begin
               cmd.res_sel = (sts.op == scl_pkg::OP_LOOKUP)
                           ? scl_pkg::RES_MISS : scl_pkg::RES_INVAL_MISS;
               state_in    = scl_pkg::FSM_RESP;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         scl_pkg::FSM_FILL: begin
            cmd.fill_step = 1'b1;
            if (sts.fill_last) begin
               cmd.res_sel = scl_pkg::RES_FILLED;
               state_in    = scl_pkg::FSM_RESP;
            end
         end
         scl_pkg::FSM_FLUSH: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_last) begin
               cmd.res_sel = scl_pkg::RES_FLUSH;
               state_in    = scl_pkg::FSM_RESP;
            end
         end
         scl_pkg::FSM_RESP: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = scl_pkg::FSM_IDLE;
            end
         end
         default: begin
            state_in = scl_pkg::FSM_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/sector_cache_lru_prefetch.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sector_cache_lru_prefetch
// Tag and LRU replacement engine of a fully associative sector cache with
// prefetch-run fill requests.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      beat
//  req_bus   in   valid/ready    op, sector, now_tick, fill_ok
//  rsp_bus   out  valid/ready    status, slot, fill_sector, fill_count
//
//  Lookup and invalidate scan one slot per cycle and end early on a hit.
//  Fill commit steps through the fill count; flush steps through all SLOTS.
//  Busy lookup and unexpected or failed fill_done answer straight from decode.
//  After reset a clearing pass zeroes the stamps, req ready low.
//  One beat at a time; a finished response waits in the output register
//  while the next beat is accepted; a stalled response holds the sequencer.
// ----------------------------------------------------------------------------
module sector_cache_lru_prefetch (
   input logic          clock,
   input logic          reset,
   scl_req_if.sink      req_bus,
   scl_rsp_if.source    rsp_bus
);

   scl_pkg::cmd_type cmd;
   scl_pkg::sts_type sts;

   scl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   scl_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .in_op      (req_bus.op),
      .in_sector  (req_bus.sector),
      .in_tick    (req_bus.now_tick),
      .in_ok      (req_bus.fill_ok),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .out_status (rsp_bus.status),
      .out_slot   (rsp_bus.slot),
      .out_sector (rsp_bus.fill_sector),
      .out_count  (rsp_bus.fill_count)
   );

endmodule

/* hw/rtl/scl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scl_checker
// Port-level assertions for the sector cache engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scl_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input scl_pkg::status_type      rsp_status,
   input scl_pkg::slot_field_type  rsp_slot,
   input scl_pkg::word_type        rsp_fill_sector,
   input scl_pkg::count_field_type rsp_fill_count
);

   logic hit_beat, done_beat, req_rsp, rsp_wait, fill_zero, count_ok;
   logic [$bits(scl_pkg::status_type) + scl_pkg::SLOT_FW + scl_pkg::WORD_W
          + scl_pkg::COUNT_FW - 1:0] rsp_beat;

   assign hit_beat  = rsp_valid && rsp_status == scl_pkg::RS_HIT;
   assign done_beat = rsp_valid && rsp_status == scl_pkg::RS_DONE;
   assign req_rsp   = rsp_valid && rsp_status == scl_pkg::RS_REQ;
   assign rsp_wait  = rsp_valid && !rsp_ready;
   assign fill_zero = rsp_fill_sector == '0 && rsp_fill_count == '0;
   assign count_ok  = rsp_fill_count == scl_pkg::count_field_type'(1)
                   || rsp_fill_count == scl_pkg::count_field_type'(scl_pkg::PREFETCH_RUN);
   assign rsp_beat  = {rsp_status, rsp_slot, rsp_fill_sector, rsp_fill_count};

   `SCL_ASSERT_IMP(a_ready_low_after_reset, clock, reset, $fell(reset), !req_ready)

   `SCL_ASSERT_IMP(a_hit_no_fill, clock, reset, hit_beat, fill_zero)

   `SCL_ASSERT_IMP(a_done_no_fill, clock, reset, done_beat, fill_zero)

   `SCL_ASSERT_IMP(a_req_count, clock, reset, req_rsp, count_ok)

   `SCL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_beat))

endmodule

bind sector_cache_lru_prefetch scl_checker u_scl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_bus.ready),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_slot        (rsp_bus.slot),
   .rsp_fill_sector (rsp_bus.fill_sector),
   .rsp_fill_count  (rsp_bus.fill_count)
);
